FILE: hw/rtl/dsvb_pkg.sv
package dsvb_pkg;

   localparam int VOLT_W     = 15;
   localparam int AUDIO_W    = 14;
   localparam int KNOB_W     = 12;
   localparam int PITCH_W    = 20;
   localparam int MODT_W     = 17;
   localparam int MANT_W     = 18;
   localparam int DIFF_W     = 13;
   localparam int BASE_W     = 32;
   localparam int PROD_W     = BASE_W + MANT_W;
   localparam int SHIFT_W    = 9;
   localparam int VOICE_MAX  = 5;
   localparam int VOICE_W    = 3;
   localparam int QUO_W      = 18;
   localparam int DVS_W      = 4;
   localparam int CSR_ADDR_W = 6;
   localparam int CSR_DATA_W = 64;
   localparam int SPREAD_W   = 7;

   typedef logic signed [VOLT_W-1:0] volt_type;

   typedef enum logic [1:0] {
      SLOT_CENTRE = 2'd0,
      SLOT_UP     = 2'd1,
      SLOT_DOWN   = 2'd2
   } slot_type;

   typedef struct packed {
      logic               valid;
      logic [VOICE_W-1:0] voice;
      slot_type           slot;
   } tag_type;

   typedef enum logic [2:0] {
      REG_VOICE_PITCH_PACK = 3'd0,
      REG_VOICE_ENABLE     = 3'd1,
      REG_MOD_ENABLE       = 3'd2,
      REG_MOD_DEPTH        = 3'd3,
      REG_CV_PER_VOICE     = 3'd4,
      REG_SPREAD_AMOUNT    = 3'd5,
      REG_HOLD_LATCH       = 3'd6,
      REG_BASE_INCREMENT   = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [59:0]          voice_pitch_pack;
      logic [4:0]           voice_enable;
      logic [4:0]           mod_enable;
      logic signed [15:0]   mod_depth;
      logic                 cv_per_voice;
      logic [SPREAD_W-1:0]  spread_amount;
      logic                 hold_latch;
      logic [BASE_W-1:0]    base_increment;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE = 3'd0,
      ST_PREP = 3'd1,
      ST_RUN  = 3'd2,
      ST_MIX  = 3'd3,
      ST_DIV  = 3'd4,
      ST_DONE = 3'd5
   } state_type;

   // 2^(i/16) in Q16, i = 0..16
   function automatic logic [MANT_W-1:0] exp_entry(input logic [4:0] idx);
      logic [MANT_W-1:0] val;
      case (idx)
         5'd0:    val = 18'd65536;
         5'd1:    val = 18'd68438;
         5'd2:    val = 18'd71468;
         5'd3:    val = 18'd74632;
         5'd4:    val = 18'd77936;
         5'd5:    val = 18'd81386;
         5'd6:    val = 18'd84990;
         5'd7:    val = 18'd88752;
         5'd8:    val = 18'd92682;
         5'd9:    val = 18'd96785;
         5'd10:   val = 18'd101070;
         5'd11:   val = 18'd105545;
         5'd12:   val = 18'd110218;
         5'd13:   val = 18'd115098;
         5'd14:   val = 18'd120194;
         5'd15:   val = 18'd125515;
         5'd16:   val = 18'd131072;
         default: val = 18'd131072;
      endcase
      return val;
   endfunction

endpackage

FILE: hw/rtl/dsvb_req_if.sv
interface dsvb_req_if;
   logic               valid;
   logic               ready;
   dsvb_pkg::volt_type mod_voltage;
   dsvb_pkg::volt_type gate_voltage;
   dsvb_pkg::volt_type cv_voice0;
   dsvb_pkg::volt_type cv_voice1;
   dsvb_pkg::volt_type cv_voice2;
   dsvb_pkg::volt_type cv_voice3;
   dsvb_pkg::volt_type cv_voice4;

   modport source (
      output valid, mod_voltage, gate_voltage,
      output cv_voice0, cv_voice1, cv_voice2, cv_voice3, cv_voice4,
      input  ready
   );

   modport sink (
      input  valid, mod_voltage, gate_voltage,
      input  cv_voice0, cv_voice1, cv_voice2, cv_voice3, cv_voice4,
      output ready
   );
endinterface

FILE: hw/rtl/dsvb_rsp_if.sv
interface dsvb_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [dsvb_pkg::AUDIO_W-1:0] audio_out;
   logic                                gated_open;

   modport source (
      output valid, audio_out, gated_open,
      input  ready
   );

   modport sink (
      input  valid, audio_out, gated_open,
      output ready
   );
endinterface

FILE: hw/rtl/dsvb_csr.sv
module dsvb_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dsvb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dsvb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dsvb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready,
   output dsvb_pkg::cfg_type                   cfg
);

   dsvb_pkg::cfg_type       cfg_ff;
   dsvb_pkg::cfg_type       cfg_in;
   dsvb_pkg::csr_index_type reg_idx;
   logic                    wr_en;

   // registers sit on 8-byte boundaries
   assign reg_idx = dsvb_pkg::csr_index_type'(paddr[5:3]);
   assign wr_en   = psel && penable && pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (reg_idx)
            dsvb_pkg::REG_VOICE_PITCH_PACK: cfg_in.voice_pitch_pack = pwdata[59:0];
            dsvb_pkg::REG_VOICE_ENABLE:     cfg_in.voice_enable     = pwdata[4:0];
            dsvb_pkg::REG_MOD_ENABLE:       cfg_in.mod_enable       = pwdata[4:0];
            dsvb_pkg::REG_MOD_DEPTH:        cfg_in.mod_depth        = pwdata[15:0];
            dsvb_pkg::REG_CV_PER_VOICE:     cfg_in.cv_per_voice     = pwdata[0];
            dsvb_pkg::REG_SPREAD_AMOUNT:    cfg_in.spread_amount    = pwdata[6:0];
            dsvb_pkg::REG_HOLD_LATCH:       cfg_in.hold_latch       = pwdata[0];
            dsvb_pkg::REG_BASE_INCREMENT:   cfg_in.base_increment   = pwdata[31:0];
            default:                        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         dsvb_pkg::REG_VOICE_PITCH_PACK: prdata = 64'(cfg_ff.voice_pitch_pack);
         dsvb_pkg::REG_VOICE_ENABLE:     prdata = 64'(cfg_ff.voice_enable);
         dsvb_pkg::REG_MOD_ENABLE:       prdata = 64'(cfg_ff.mod_enable);
         dsvb_pkg::REG_MOD_DEPTH:        prdata = 64'(unsigned'(cfg_ff.mod_depth));
         dsvb_pkg::REG_CV_PER_VOICE:     prdata = 64'(cfg_ff.cv_per_voice);
         dsvb_pkg::REG_SPREAD_AMOUNT:    prdata = 64'(cfg_ff.spread_amount);
         dsvb_pkg::REG_HOLD_LATCH:       prdata = 64'(cfg_ff.hold_latch);
         dsvb_pkg::REG_BASE_INCREMENT:   prdata = 64'(cfg_ff.base_increment);
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

FILE: hw/rtl/dsvb_inc_unit.sv
module dsvb_inc_unit #(
   parameter int PHASE_BITS = 32
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  dsvb_pkg::tag_type                    in_tag,
   input  logic signed [dsvb_pkg::PITCH_W-1:0]  in_pitch,
   input  logic [dsvb_pkg::BASE_W-1:0]          base_inc,
   output dsvb_pkg::tag_type                    out_tag,
   output logic [PHASE_BITS-1:0]                out_inc
);

   localparam int SHIFT_BIAS = 48 - PHASE_BITS;
   localparam logic [PHASE_BITS-1:0] HALF = {1'b1, {(PHASE_BITS-1){1'b0}}};
   localparam logic [dsvb_pkg::SHIFT_W-1:0] MAX_LEFT  = 9'd40;
   localparam logic [dsvb_pkg::SHIFT_W-1:0] MAX_RIGHT = 9'd63;

   // stage 0: pitch word
   dsvb_pkg::tag_type                       tag0_ff;
   logic signed [dsvb_pkg::PITCH_W-1:0]     pitch_ff;
   // stage 1: mantissa and shift
   dsvb_pkg::tag_type                       tag1_ff;
   logic [dsvb_pkg::MANT_W-1:0]             mant_ff, mant_in;
   logic signed [dsvb_pkg::SHIFT_W-1:0]     shift1_ff, shift1_in;
   // stage 2: scaled increment
   dsvb_pkg::tag_type                       tag2_ff;
   logic [dsvb_pkg::PROD_W-1:0]             prod_ff, prod_in;
   logic signed [dsvb_pkg::SHIFT_W-1:0]     shift2_ff;
   // stage 3: limited increment
   dsvb_pkg::tag_type                       tag3_ff;
   logic [PHASE_BITS-1:0]                   inc_ff, inc_in;

   logic signed [7:0]                       octave;
   logic [3:0]                              seg;
   logic [7:0]                              frac;
   logic [dsvb_pkg::MANT_W-1:0]             t_lo, t_hi;
   logic [dsvb_pkg::DIFF_W-1:0]             t_diff;
   logic [dsvb_pkg::DIFF_W+7:0]             interp;
   logic [dsvb_pkg::SHIFT_W-1:0]            right_full;
   logic [5:0]                              amt;
   logic [dsvb_pkg::PROD_W-1:0]             limit;
   logic [dsvb_pkg::PROD_W-1:0]             shifted;

   // octave, table segment and fraction of the segment
   always_comb begin
      octave    = pitch_ff[dsvb_pkg::PITCH_W-1:12];
      seg       = pitch_ff[11:8];
      frac      = pitch_ff[7:0];
      t_lo      = dsvb_pkg::exp_entry({1'b0, seg});
      t_hi      = dsvb_pkg::exp_entry(5'({1'b0, seg}) + 5'd1);
      t_diff    = dsvb_pkg::DIFF_W'(t_hi - t_lo);
      interp    = t_diff * frac;
      mant_in   = t_lo + dsvb_pkg::MANT_W'(interp[dsvb_pkg::DIFF_W+7:8]);
      shift1_in = {octave[7], octave} - dsvb_pkg::SHIFT_W'(SHIFT_BIAS);
   end

   assign prod_in = base_inc * mant_ff;

   always_comb begin
      right_full = '0 - unsigned'(shift2_ff);
      limit      = '0;
      shifted    = '0;
      amt        = '0;
      if (!shift2_ff[dsvb_pkg::SHIFT_W-1]) begin
         // left shift, saturating at half a cycle
         amt     = (unsigned'(shift2_ff) > MAX_LEFT) ? 6'(MAX_LEFT) : shift2_ff[5:0];
         limit   = dsvb_pkg::PROD_W'(HALF) >> amt;
         shifted = prod_ff << amt;
         inc_in  = (prod_ff > limit) ? HALF : shifted[PHASE_BITS-1:0];
      end else begin
         amt     = (right_full > MAX_RIGHT) ? 6'(MAX_RIGHT) : right_full[5:0];
         shifted = prod_ff >> amt;
         inc_in  = (shifted > dsvb_pkg::PROD_W'(HALF)) ? HALF : shifted[PHASE_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tag0_ff <= '0;
         tag1_ff <= '0;
         tag2_ff <= '0;
         tag3_ff <= '0;
      end else begin
         tag0_ff <= in_tag;
         tag1_ff <= tag0_ff;
         tag2_ff <= tag1_ff;
         tag3_ff <= tag2_ff;
      end
   end

   always_ff @(posedge clock) begin
      pitch_ff  <= in_pitch;
      mant_ff   <= mant_in;
      shift1_ff <= shift1_in;
      prod_ff   <= prod_in;
      shift2_ff <= shift1_ff;
      inc_ff    <= inc_in;
   end

   assign out_tag = tag3_ff;
   assign out_inc = inc_ff;

endmodule

FILE: hw/rtl/dsvb_div.sv
module dsvb_div (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   input  logic [dsvb_pkg::QUO_W-1:0]       dividend,
   input  logic [dsvb_pkg::DVS_W-1:0]       divisor,
   output logic                             done,
   output logic [dsvb_pkg::QUO_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(dsvb_pkg::QUO_W + 1);

   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic                           done_ff, done_in;
   logic [dsvb_pkg::QUO_W-1:0]     quo_ff, quo_in;
   logic [dsvb_pkg::DVS_W-1:0]     rem_ff, rem_in;
   logic [dsvb_pkg::DVS_W-1:0]     dvs_ff, dvs_in;
   logic [dsvb_pkg::DVS_W:0]       trial;
   logic                           fits;

   // restoring divide, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, quo_ff[dsvb_pkg::QUO_W-1]};
      fits    = trial >= {1'b0, dvs_ff};
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      done_in = 1'b0;
      if (start) begin
         cnt_in = CNT_W'(dsvb_pkg::QUO_W);
         quo_in = dividend;
         rem_in = '0;
         dvs_in = divisor;
      end else if (cnt_ff != '0) begin
         cnt_in  = cnt_ff - 1'b1;
         quo_in  = {quo_ff[dsvb_pkg::QUO_W-2:0], fits};
         rem_in  = fits ? dsvb_pkg::DVS_W'(trial - {1'b0, dvs_ff})
                        : trial[dsvb_pkg::DVS_W-1:0];
         done_in = (cnt_ff == CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

FILE: hw/rtl/detuned_saw_voice_bank.sv
// channel   dir  handshake          payload
// req       in   valid/ready        mod_voltage, gate_voltage, cv_voice0..cv_voice4
// rsp       out  valid/ready        audio_out, gated_open
// apb cfg   in   psel/penable/pready  paddr, pwdata, prdata (8 registers, 8-byte stride)
//
// a sample passes an accept (idle) state and a prep state, then a pass of all oscillators
// through the 4-stage shared exp2/increment pipeline, then an 18-step divider for the mix;
// a muted sample skips the divider.
// reset (synchronous) clears the CSR registers, all oscillator phases and the output valid flag.
// req.ready is high only between samples; a finished sample waits in the output register
// and the next transfer is taken while rsp is stalled.
module detuned_saw_voice_bank #(
   parameter int VOICE_COUNT = 5,
   parameter int PHASE_BITS  = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   dsvb_req_if.sink                            req,
   dsvb_rsp_if.source                          rsp,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [dsvb_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [dsvb_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [dsvb_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                                pready
);

   localparam int OSC_COUNT = 3 * VOICE_COUNT;
   localparam int OSC_IDX_W = $clog2(OSC_COUNT);
   localparam int SUM_W     = PHASE_BITS + 4;
   localparam int SUM5_W    = PHASE_BITS + 7;
   localparam int Q_LSB     = PHASE_BITS - 11;
   localparam int RES_W     = 20;
   localparam logic [4:0] VOICE_MASK = 5'((1 << VOICE_COUNT) - 1);
   localparam logic [dsvb_pkg::VOICE_W-1:0] LAST_VOICE = dsvb_pkg::VOICE_W'(VOICE_COUNT - 1);

   dsvb_pkg::cfg_type    cfg;
   dsvb_pkg::state_type  state_ff, state_in;

   // latched sample inputs
   logic signed [dsvb_pkg::VOLT_W-1:0]  mod_v_ff, mod_v_in;
   logic signed [dsvb_pkg::VOLT_W-1:0]  cv_ff [dsvb_pkg::VOICE_MAX];
   logic signed [dsvb_pkg::VOLT_W-1:0]  cv_in [dsvb_pkg::VOICE_MAX];
   logic                                open_ff, open_in;
   logic signed [dsvb_pkg::MODT_W-1:0]  modt_ff, modt_in;

   // issue counters
   logic [dsvb_pkg::VOICE_W-1:0]        iss_v_ff, iss_v_in;
   dsvb_pkg::slot_type                  iss_k_ff, iss_k_in;
   logic                                iss_on_ff, iss_on_in;

   logic [PHASE_BITS-1:0]               phase_ff [OSC_COUNT];
   logic [PHASE_BITS-1:0]               phase_in [OSC_COUNT];
   logic [SUM_W-1:0]                    sum_ff, sum_in;
   logic signed [dsvb_pkg::AUDIO_W-1:0] res_ff, res_in;

   logic                                rsp_valid_ff, rsp_valid_in;
   logic signed [dsvb_pkg::AUDIO_W-1:0] audio_ff, audio_in;
   logic                                gated_ff, gated_in;

   // control from the sequencer
   logic                                take_req;
   logic                                prep;
   logic                                issue;
   logic                                div_start;
   logic                                res_mute;
   logic                                load_out;

   dsvb_pkg::tag_type                   iss_tag;
   dsvb_pkg::tag_type                   out_tag;
   logic signed [dsvb_pkg::PITCH_W-1:0] pitch;
   logic [PHASE_BITS-1:0]               out_inc;

   logic signed [dsvb_pkg::KNOB_W-1:0]  knob;
   logic [dsvb_pkg::VOICE_W-1:0]        cv_sel;
   logic signed [dsvb_pkg::VOLT_W-1:0]  cv;
   logic signed [dsvb_pkg::PITCH_W-1:0] knob_term, cv_term, mod_term, spr_term, spr_ext;
   logic signed [30:0]                  depth_prod;
   logic signed [30:0]                  depth_round;

   logic [4:0]                          wr_sum;
   logic [OSC_IDX_W-1:0]                wr_idx;
   logic [PHASE_BITS-1:0]               new_phase;
   logic                                last_out;

   logic [2:0]                          voice_cnt;
   logic                                mute;
   logic [SUM5_W-1:0]                   sum5;
   logic [dsvb_pkg::DVS_W-1:0]          div_dvs;
   logic                                div_done;
   logic [dsvb_pkg::QUO_W-1:0]          div_q;
   logic signed [RES_W-1:0]             res_wide;
   logic                                out_free;

   dsvb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   dsvb_inc_unit #(
      .PHASE_BITS (PHASE_BITS)
   ) u_inc (
      .clock    (clock),
      .reset    (reset),
      .in_tag   (iss_tag),
      .in_pitch (pitch),
      .base_inc (cfg.base_increment),
      .out_tag  (out_tag),
      .out_inc  (out_inc)
   );

   dsvb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum5[Q_LSB +: dsvb_pkg::QUO_W]),
      .divisor  (div_dvs),
      .done     (div_done),
      .quotient (div_q)
   );

   // ---------------- sequencer ----------------
   assign last_out = out_tag.valid && (out_tag.voice == LAST_VOICE)
                     && (out_tag.slot == dsvb_pkg::SLOT_DOWN);
   assign voice_cnt = 3'($countones(cfg.voice_enable & VOICE_MASK));
   assign mute      = (voice_cnt == 3'd0) || !open_ff;
   assign out_free  = !rsp_valid_ff || rsp.ready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dsvb_pkg::ST_IDLE: if (req.valid) state_in = dsvb_pkg::ST_PREP;
         dsvb_pkg::ST_PREP: state_in = dsvb_pkg::ST_RUN;
         dsvb_pkg::ST_RUN:  if (last_out) state_in = dsvb_pkg::ST_MIX;
         dsvb_pkg::ST_MIX:  state_in = mute ? dsvb_pkg::ST_DONE : dsvb_pkg::ST_DIV;
         dsvb_pkg::ST_DIV:  if (div_done) state_in = dsvb_pkg::ST_DONE;
         dsvb_pkg::ST_DONE: if (out_free) state_in = dsvb_pkg::ST_IDLE;
         default:           state_in = dsvb_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req.ready = 1'b0;
      take_req  = 1'b0;
      prep      = 1'b0;
      issue     = 1'b0;
      div_start = 1'b0;
      res_mute  = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         dsvb_pkg::ST_IDLE: begin
            req.ready = 1'b1;
            take_req  = req.valid;
         end
         dsvb_pkg::ST_PREP: prep = 1'b1;
         dsvb_pkg::ST_RUN:  issue = iss_on_ff;
         dsvb_pkg::ST_MIX: begin
            div_start = !mute;
            res_mute  = mute;
         end
         dsvb_pkg::ST_DIV:  ;
         dsvb_pkg::ST_DONE: load_out = out_free;
         default:           ;
      endcase
   end

   // ---------------- pitch of the oscillator being issued ----------------
   always_comb begin
      knob        = cfg.voice_pitch_pack[dsvb_pkg::KNOB_W * iss_v_ff +: dsvb_pkg::KNOB_W];
      cv_sel      = cfg.cv_per_voice ? iss_v_ff : '0;
      cv          = cv_ff[cv_sel];
      knob_term   = {{(dsvb_pkg::PITCH_W-dsvb_pkg::KNOB_W-4){knob[dsvb_pkg::KNOB_W-1]}},
                     knob, 4'b0};
      cv_term     = {{(dsvb_pkg::PITCH_W-dsvb_pkg::VOLT_W-2){cv[dsvb_pkg::VOLT_W-1]}},
                     cv, 2'b0};
      mod_term    = cfg.mod_enable[iss_v_ff]
                  ? {{(dsvb_pkg::PITCH_W-dsvb_pkg::MODT_W){modt_ff[dsvb_pkg::MODT_W-1]}},
                     modt_ff}
                  : '0;
      spr_ext     = {{(dsvb_pkg::PITCH_W-dsvb_pkg::SPREAD_W){1'b0}}, cfg.spread_amount};
      case (iss_k_ff)
         dsvb_pkg::SLOT_UP:   spr_term = spr_ext;
         dsvb_pkg::SLOT_DOWN: spr_term = -spr_ext;
         default:             spr_term = '0;
      endcase
      pitch         = knob_term + cv_term + mod_term + spr_term;
      iss_tag.valid = issue;
      iss_tag.voice = iss_v_ff;
      iss_tag.slot  = iss_k_ff;
   end

   // rounded attenuverter product, floor of (depth*mod + 8192) / 16384
   assign depth_prod  = cfg.mod_depth * mod_v_ff;
   assign depth_round = depth_prod + 31'sd8192;

   // ---------------- datapath next values ----------------
   always_comb begin
      wr_sum    = 5'({out_tag.voice, 1'b0}) + 5'(out_tag.voice) + 5'(out_tag.slot);
      wr_idx    = wr_sum[OSC_IDX_W-1:0];
      new_phase = phase_ff[wr_idx] + out_inc;
      sum5      = (SUM5_W'(sum_ff) << 2) + SUM5_W'(sum_ff);
      div_dvs   = dsvb_pkg::DVS_W'({voice_cnt, 1'b0}) + dsvb_pkg::DVS_W'(voice_cnt);
      res_wide  = signed'(RES_W'(div_q)) - RES_W'(5120) + signed'(RES_W'({voice_cnt, 9'b0}));

      mod_v_in  = mod_v_ff;
      cv_in     = cv_ff;
      open_in   = open_ff;
      if (take_req) begin
         mod_v_in = req.mod_voltage;
         cv_in[0] = req.cv_voice0;
         cv_in[1] = req.cv_voice1;
         cv_in[2] = req.cv_voice2;
         cv_in[3] = req.cv_voice3;
         cv_in[4] = req.cv_voice4;
         open_in  = cfg.hold_latch || (req.gate_voltage > 15'sd5120);
      end

      modt_in = prep ? depth_round[30:14] : modt_ff;

      iss_v_in  = iss_v_ff;
      iss_k_in  = iss_k_ff;
      iss_on_in = iss_on_ff;
      if (prep) begin
         iss_v_in  = '0;
         iss_k_in  = dsvb_pkg::SLOT_CENTRE;
         iss_on_in = 1'b1;
      end else if (issue) begin
         case (iss_k_ff)
            dsvb_pkg::SLOT_CENTRE: iss_k_in = dsvb_pkg::SLOT_UP;
            dsvb_pkg::SLOT_UP:     iss_k_in = dsvb_pkg::SLOT_DOWN;
            default: begin
               iss_k_in  = dsvb_pkg::SLOT_CENTRE;
               iss_v_in  = iss_v_ff + 1'b1;
               iss_on_in = (iss_v_ff != LAST_VOICE);
            end
         endcase
      end

      phase_in = phase_ff;
      sum_in   = sum_ff;
      if (prep) begin
         sum_in = '0;
      end else if (out_tag.valid) begin
         phase_in[wr_idx] = new_phase;
         if (cfg.voice_enable[out_tag.voice]) begin
            sum_in = sum_ff + SUM_W'(new_phase);
         end
      end

      res_in = res_ff;
      if (res_mute) begin
         res_in = '0;
      end else if (div_done) begin
         if (res_wide > RES_W'(8191)) begin
            res_in = 14'sd8191;
         end else if (res_wide < -RES_W'(8192)) begin
            res_in = 14'sh2000;
         end else begin
            res_in = res_wide[dsvb_pkg::AUDIO_W-1:0];
         end
      end

      rsp_valid_in = rsp_valid_ff;
      audio_in     = audio_ff;
      gated_in     = gated_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
         audio_in     = res_ff;
         gated_in     = open_ff;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dsvb_pkg::ST_IDLE;
         iss_on_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < OSC_COUNT; i++) begin
            phase_ff[i] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         iss_on_ff    <= iss_on_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff     <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      mod_v_ff <= mod_v_in;
      cv_ff    <= cv_in;
      open_ff  <= open_in;
      modt_ff  <= modt_in;
      iss_v_ff <= iss_v_in;
      iss_k_ff <= iss_k_in;
      sum_ff   <= sum_in;
      res_ff   <= res_in;
      audio_ff <= audio_in;
      gated_ff <= gated_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.audio_out  = audio_ff;
   assign rsp.gated_open = gated_ff;

   // ---------------- checks ----------------
   a_tag_only_in_run: assert property (@(posedge clock) disable iff (reset)
      out_tag.valid |-> state_ff == dsvb_pkg::ST_RUN)
      else $error("oscillator update outside the run phase");

   a_last_leaves_run: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsvb_pkg::ST_RUN && last_out) |=> state_ff == dsvb_pkg::ST_MIX)
      else $error("sequencer did not leave run after last oscillator");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == dsvb_pkg::ST_DIV)
      else $error("divider finished outside the divide phase");

   a_closed_is_silent: assert property (@(posedge clock) disable iff (reset)
      (rsp.valid && !rsp.gated_open) |-> rsp.audio_out == '0)
      else $error("audio present while output closed");

   a_no_issue_before_prep: assert property (@(posedge clock) disable iff (reset)
      (state_ff == dsvb_pkg::ST_PREP) |=> (iss_on_ff && iss_v_ff == '0))
      else $error("issue counters not restarted");

endmodule
